// ===== sv/mbep_pkg.sv =====
// ============================================================================
// MIDI byte event parser package
// Shared event codes, MIDI byte constants and the job record type.
// ============================================================================
package mbep_pkg;

	// Event codes as they appear on the event_kind result port.
	typedef enum logic [2:0] {
		EV_CLOCK    = 3'd0,
		EV_START    = 3'd1,
		EV_STOP     = 3'd2,
		EV_NOTE_ON  = 3'd3,
		EV_NOTE_OFF = 3'd4
	} ev_kind_t;

	// Real-time bytes.
	localparam logic [7:0] RT_FIRST     = 8'hF8;
	localparam logic [7:0] RT_TICK      = 8'hF8;
	localparam logic [7:0] RT_SEQ_START = 8'hFA;
	localparam logic [7:0] RT_CONTINUE  = 8'hFB;
	localparam logic [7:0] RT_STOP      = 8'hFC;

	// Channel message classes (high nibble of a status byte).
	localparam logic [3:0] MSG_NOTE_OFF   = 4'h8;
	localparam logic [3:0] MSG_NOTE_ON    = 4'h9;
	localparam logic [3:0] MSG_PITCH_BEND = 4'hE;

	// Number of data bytes that follow a note or pitch-bend status.
	localparam logic [1:0] DATA_COUNT = 2'd2;

	// One classified request from the front end. A start byte yields one job
	// with pair set; the back end expands it into a stop and then a start.
	typedef struct packed {
		logic       pair;
		ev_kind_t   kind;
		logic [3:0] channel;
		logic [6:0] note;
	} job_t;

endpackage

// ===== sv/mbep_front.sv =====
// ============================================================================
// MIDI parser front end
// Classifies each accepted byte, tracks running status and produces jobs.
// ============================================================================
module mbep_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic [7:0]       rx_byte,
	output logic             job_push,
	output mbep_pkg::job_t   job
);

	logic [7:0] status_q, status_d;
	logic [1:0] count_q, count_d;
	logic [1:0] index_q, index_d;
	logic [6:0] data0_q, data0_d;
	logic       hit;

	always_comb begin
		status_d = status_q;
		count_d  = count_q;
		index_d  = index_q;
		data0_d  = data0_q;
		hit      = 1'b0;
		job      = '{pair: 1'b0, kind: mbep_pkg::EV_CLOCK, channel: 4'd0, note: 7'd0};

		if (rx_byte >= mbep_pkg::RT_FIRST) begin
			// Real-time bytes leave the parser state alone.
			case (rx_byte)
				mbep_pkg::RT_TICK: begin
					hit      = 1'b1;
					job.kind = mbep_pkg::EV_CLOCK;
				end
				mbep_pkg::RT_SEQ_START: begin
					hit      = 1'b1;
					job.pair = 1'b1;
					job.kind = mbep_pkg::EV_STOP;
				end
				mbep_pkg::RT_CONTINUE: begin
					hit      = 1'b1;
					job.kind = mbep_pkg::EV_START;
				end
				mbep_pkg::RT_STOP: begin
					hit      = 1'b1;
					job.kind = mbep_pkg::EV_STOP;
				end
				default: begin
					hit = 1'b0;
				end
			endcase
		end else begin
			if (rx_byte[7]) begin
				status_d = rx_byte;
				if (rx_byte[7:4] inside {mbep_pkg::MSG_NOTE_OFF, mbep_pkg::MSG_NOTE_ON,
						mbep_pkg::MSG_PITCH_BEND}) begin
					count_d = mbep_pkg::DATA_COUNT;
					index_d = 2'd0;
				end
			end else if (count_q != 2'd0 && index_q < mbep_pkg::DATA_COUNT) begin
				// Only the first data byte needs storage; the second one is the
				// current byte whenever a message completes.
				if (index_q == 2'd0) begin
					data0_d = rx_byte[6:0];
				end
				index_d = index_q + 2'd1;
			end

			if (index_d == count_d) begin
				index_d     = 2'd0;
				job.channel = status_d[3:0];
				job.note    = data0_d;
				if (status_d[7:4] == mbep_pkg::MSG_NOTE_ON) begin
					hit      = 1'b1;
					job.kind = (rx_byte[6:0] != 7'd0) ? mbep_pkg::EV_NOTE_ON
						: mbep_pkg::EV_NOTE_OFF;
				end else if (status_d[7:4] == mbep_pkg::MSG_NOTE_OFF) begin
					hit      = 1'b1;
					job.kind = mbep_pkg::EV_NOTE_OFF;
				end
			end
		end
	end

	assign job_push = accept & hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q <= 8'd0;
			count_q  <= 2'd0;
			index_q  <= 2'd0;
		end else if (accept) begin
			status_q <= status_d;
			count_q  <= count_d;
			index_q  <= index_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data0_q <= data0_d;
		end
	end

endmodule

// ===== sv/mbep_queue.sv =====
// ============================================================================
// MIDI parser job queue
// Small first-in first-out store between the front and back ends.
// ============================================================================
module mbep_queue #(
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  mbep_pkg::job_t   wr_job,
	input  logic             rd_en,
	output mbep_pkg::job_t   rd_job,
	output logic             full,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	mbep_pkg::job_t mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign full   = (count_q == CW'(DEPTH));
	assign empty  = (count_q == '0);
	assign rd_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== sv/mbep_back.sv =====
// ============================================================================
// MIDI parser back end
// Expands jobs into events and holds the result register.
// ============================================================================
module mbep_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             job_avail,
	input  mbep_pkg::job_t   job,
	output logic             job_take,
	input  logic             ev_taken,
	output logic             ev_valid,
	output logic [2:0]       ev_kind,
	output logic [3:0]       ev_channel,
	output logic [6:0]       ev_note,
	output logic             ev_last,
	output logic             pend_start
);

	logic       valid_q;
	logic       pend_q;
	logic [2:0] kind_q;
	logic [3:0] channel_q;
	logic [6:0] note_q;
	logic       last_q;
	logic       load;

	// The result register may be refilled when it is empty or being drained.
	assign load     = !valid_q || ev_taken;
	assign job_take = load && !pend_q && job_avail;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pend_q  <= 1'b0;
		end else if (load) begin
			valid_q <= pend_q || job_avail;
			pend_q  <= !pend_q && job_avail && job.pair;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (pend_q) begin
				kind_q    <= mbep_pkg::EV_START;
				channel_q <= 4'd0;
				note_q    <= 7'd0;
				last_q    <= 1'b1;
			end else begin
				kind_q    <= job.kind;
				channel_q <= job.channel;
				note_q    <= job.note;
				last_q    <= !job.pair;
			end
		end
	end

	assign ev_valid   = valid_q;
	assign ev_kind    = kind_q;
	assign ev_channel = channel_q;
	assign ev_note    = note_q;
	assign ev_last    = last_q;
	assign pend_start = pend_q;

endmodule

// ===== sv/midi_byte_event_parser_unit.sv =====
// ============================================================================
// MIDI byte event parser
// Parses received MIDI bytes with running status into clock, transport and
// note events.
// ============================================================================
//
//  Channel  | Handshake     | Payload
//  ---------+---------------+------------------------------------------------
//  input    | push / full   | rx_byte
//  result   | pop / empty   | event_kind, channel, note, last
//
// A byte is accepted at any edge where push is high and full is low, so bytes
// can follow back to back. At that edge the running status is updated and at
// most one request enters the job queue; it then moves into the result register
// once that is free, and empty falls. A start byte gives a stop and then a
// start from one request. full is high exactly while the queue holds
// JOB_DEPTH requests. Reset clears all state except stored data.
//
module midi_byte_event_parser_unit #(
	parameter int JOB_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] rx_byte,
	input  logic       pop,
	output logic       empty,
	output logic [2:0] event_kind,
	output logic [3:0] channel,
	output logic [6:0] note,
	output logic       last
);

	logic           accept;
	logic           job_push;
	mbep_pkg::job_t job_in;
	mbep_pkg::job_t job_head;
	logic           q_empty;
	logic           q_full;
	logic           job_take;
	logic           ev_valid;
	logic           pend_start;

	// A byte is taken whenever the job queue has room, whether or not it
	// will produce a request.
	assign accept = push && !q_full;
	assign full   = q_full;

	mbep_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.rx_byte  (rx_byte),
		.job_push (job_push),
		.job      (job_in)
	);

	mbep_queue #(
		.DEPTH (JOB_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (job_push),
		.wr_job (job_in),
		.rd_en  (job_take),
		.rd_job (job_head),
		.full   (q_full),
		.empty  (q_empty)
	);

	// The back end drains the queue independently and owns the result
	// register, so the front keeps accepting while a result waits.
	mbep_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_avail  (!q_empty),
		.job        (job_head),
		.job_take   (job_take),
		.ev_taken   (pop && ev_valid),
		.ev_valid   (ev_valid),
		.ev_kind    (event_kind),
		.ev_channel (channel),
		.ev_note    (note),
		.ev_last    (last),
		.pend_start (pend_start)
	);

	assign empty = !ev_valid;

	// While the second half of a start byte is pending, the result register
	// must hold the leading stop event.
	a_pend_holds_stop: assert property (@(posedge clk) disable iff (!arst_n)
		pend_start |-> (!empty && event_kind == mbep_pkg::EV_STOP && !last))
		else $error("pending start without a leading stop on the result ports");

	// Only the stop half of a start byte may be a non-final event.
	a_nonlast_is_stop: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !last) |-> (event_kind == mbep_pkg::EV_STOP))
		else $error("non-final event that is not a stop");

	// Taking the leading stop must expose the start event next.
	a_stop_then_start: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && !last) |=>
			(!empty && event_kind == mbep_pkg::EV_START && last))
		else $error("start event did not follow the leading stop");

	// The front end never writes a request into a full queue.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		job_push |-> !q_full)
		else $error("job written into a full queue");

endmodule

// ===== tb/sv/midi_byte_event_parser_unit_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// MIDI byte event parser testbench
// Sends directed and random MIDI byte streams through the parser and checks
// every event against a running-status model kept in the testbench.
// ============================================================================
//
// The stimulus process fills a queue of pending bytes phase by phase. A driver
// on the falling edge offers them on push/rx_byte, and a monitor on the rising
// edge sees which requests the block takes. Every accepted byte runs through
// the model at once, which appends the events it should produce to a queue
// of predicted events. The same monitor compares each popped result with the
// oldest predicted event, field by field.
//
// Phases: a directed pass with no idling, then random message streams with no
// idling, with the sender idle most of the time, with the receiver stalling
// most of the time, with both idling a little, and finally a pass in which
// the receiver holds off for a long stretch so that the job queue fills and
// full is raised. The sender waits for all predicted events between phases.
//
module midi_byte_event_parser_unit_tb;

	localparam int CLK_HALF    = 5;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 150;
	localparam int TAIL_CYCLES = 20;
	localparam int MAX_PRINTS  = 30;

	// Status classes and system bytes that the stimulus uses but the package does
	// not name, because the block stores them as running status or ignores them.
	localparam logic [3:0] MSG_POLY_TOUCH = 4'hA;
	localparam logic [3:0] MSG_CONTROL    = 4'hB;
	localparam logic [3:0] MSG_PROGRAM    = 4'hC;
	localparam logic [3:0] MSG_CHAN_TOUCH = 4'hD;
	localparam logic [3:0] MSG_SYSTEM     = 4'hF;
	localparam logic [7:0] SYSEX_START    = 8'hF0;
	localparam logic [7:0] SYSEX_END      = 8'hF7;
	localparam logic [7:0] RT_UNDEF_F9    = 8'hF9;
	localparam logic [7:0] RT_UNDEF_FD    = 8'hFD;
	localparam logic [7:0] RT_SENSE       = 8'hFE;
	localparam logic [7:0] RT_SYS_RESET   = 8'hFF;

	typedef struct {
		mbep_pkg::ev_kind_t kind;
		logic [3:0]         channel;
		logic [6:0]         note;
		logic               last;
	} midi_event_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic [7:0] rx_byte = 8'h00;
	logic       pop = 1'b0;
	logic       full;
	logic       empty;
	logic [2:0] event_kind;
	logic [3:0] channel;
	logic [6:0] note;
	logic       last;

	// Bytes waiting to be offered and events waiting to be popped.
	logic [7:0]  tx_bytes[$];
	midi_event_t predicted_events[$];

	// Parser state as the model sees it.
	logic [7:0] run_status = 8'h00;
	logic [1:0] data_count = 2'd0;
	logic [1:0] byte_pos = 2'd0;
	logic [6:0] note_data[2];

	int  send_idle_pct = 0;
	int  recv_stall_pct = 0;
	bit  hold_go = 1'b0;
	logic rx_hold = 1'b0;
	bit  byte_taken = 1'b0;
	int  error_count = 0;
	int  cycle_count = 0;
	int  counted_bytes = 0;

	midi_byte_event_parser_unit i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.rx_byte    (rx_byte),
		.pop        (pop),
		.empty      (empty),
		.event_kind (event_kind),
		.channel    (channel),
		.note       (note),
		.last       (last)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	task automatic report_mismatch(input string what);
		error_count++;
		if (error_count <= MAX_PRINTS)
			$display("[%0t] mismatch: %s", $time, what);
	endtask

	task automatic add_event(input mbep_pkg::ev_kind_t kind, input logic [3:0] chan,
			input logic [6:0] num, input logic fin);
		midi_event_t ev;
		ev.kind = kind;
		ev.channel = chan;
		ev.note = num;
		ev.last = fin;
		predicted_events.push_back(ev);
	endtask

	// Running-status parser. Real-time bytes leave the state alone; a start
	// byte turns into a stop event followed by a start event.
	task automatic predict_events(input logic [7:0] b);
		if (b >= mbep_pkg::RT_FIRST) begin
			case (b)
			mbep_pkg::RT_TICK: add_event(mbep_pkg::EV_CLOCK, 4'd0, 7'd0, 1'b1);
			mbep_pkg::RT_SEQ_START: begin
				add_event(mbep_pkg::EV_STOP, 4'd0, 7'd0, 1'b0);
				add_event(mbep_pkg::EV_START, 4'd0, 7'd0, 1'b1);
			end
			mbep_pkg::RT_CONTINUE: add_event(mbep_pkg::EV_START, 4'd0, 7'd0, 1'b1);
			mbep_pkg::RT_STOP: add_event(mbep_pkg::EV_STOP, 4'd0, 7'd0, 1'b1);
			default: ;
			endcase
		end else begin
			if (b[7]) begin
				run_status = b;
				// Only note and pitch-bend statuses rearm the data count.
				if (b[7:4] == mbep_pkg::MSG_NOTE_OFF || b[7:4] == mbep_pkg::MSG_NOTE_ON ||
						b[7:4] == mbep_pkg::MSG_PITCH_BEND) begin
					data_count = mbep_pkg::DATA_COUNT;
					byte_pos = 2'd0;
				end
			end else if (data_count != 2'd0 && byte_pos < mbep_pkg::DATA_COUNT) begin
				// Data with no count armed is dropped.
				note_data[byte_pos[0]] = b[6:0];
				byte_pos = byte_pos + 2'd1;
			end
			// The completion check runs after status bytes too; it can only
			// decode a note once both data bytes of the message are in.
			if (byte_pos == data_count) begin
				if (run_status[7:4] == mbep_pkg::MSG_NOTE_ON) begin
					if (note_data[1] == 7'd0)
						add_event(mbep_pkg::EV_NOTE_OFF, run_status[3:0], note_data[0],
							1'b1);
					else
						add_event(mbep_pkg::EV_NOTE_ON, run_status[3:0], note_data[0],
							1'b1);
				end else if (run_status[7:4] == mbep_pkg::MSG_NOTE_OFF) begin
					add_event(mbep_pkg::EV_NOTE_OFF, run_status[3:0], note_data[0], 1'b1);
				end
				byte_pos = 2'd0;
			end
		end
	endtask

	// Rising edge: take note of accepted requests and check popped events.
	always @(posedge clk) begin
		midi_event_t ev;
		byte_taken = arst_n && push && !full;
		if (byte_taken)
			predict_events(rx_byte);
		if (arst_n && pop && !empty) begin
			if (predicted_events.size() == 0) begin
				report_mismatch($sformatf("event kind %0d with nothing predicted",
					event_kind));
			end else begin
				ev = predicted_events.pop_front();
				if (event_kind !== ev.kind)
					report_mismatch($sformatf("event_kind %0d, predicted %0d",
						event_kind, ev.kind));
				if (channel !== ev.channel)
					report_mismatch($sformatf("channel %0d, predicted %0d",
						channel, ev.channel));
				if (note !== ev.note)
					report_mismatch($sformatf("note %0d, predicted %0d",
						note, ev.note));
				if (last !== ev.last)
					report_mismatch($sformatf("last %0b, predicted %0b",
						last, ev.last));
			end
		end
	end

	// Falling edge: retire the byte that was taken and offer the next one.
	// While idle, rx_byte carries noise that the block must ignore.
	always @(negedge clk) begin
		if (byte_taken)
			void'(tx_bytes.pop_front());
		if (arst_n && tx_bytes.size() != 0 &&
				$urandom_range(99) >= send_idle_pct) begin
			push <= 1'b1;
			rx_byte <= tx_bytes[0];
		end else begin
			push <= 1'b0;
			rx_byte <= 8'($urandom_range(255));
		end
	end

	always @(negedge clk) begin
		if (!arst_n || rx_hold)
			pop <= 1'b0;
		else
			pop <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Long receiver hold-off, counted here so that the sender keeps going.
	initial begin
		wait (hold_go);
		@(negedge clk);
		rx_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(negedge clk);
		rx_hold <= 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("midi_byte_event_parser_unit_tb NOT OK");
			$finish;
		end
	end

	// Ignored real-time bytes do not count toward the length of a phase.
	task automatic add_byte(input logic [7:0] b);
		tx_bytes.push_back(b);
		if (b != RT_UNDEF_F9 && b != RT_UNDEF_FD && b != RT_SENSE &&
				b != RT_SYS_RESET)
			counted_bytes++;
	endtask

	task automatic maybe_realtime();
		if ($urandom_range(99) < 10)
			add_byte({5'b11111, 3'($urandom_range(7))});
	endtask

	task automatic add_data_pair(input bit zero_second);
		add_byte(8'($urandom_range(127)));
		maybe_realtime();
		add_byte(zero_second ? 8'h00 : 8'($urandom_range(127)));
		maybe_realtime();
	endtask

	// One random message: mostly well-formed note traffic with running status,
	// mixed with other statuses, lone real-time bytes and raw noise.
	task automatic add_message();
		int pick;
		logic [3:0] chan;
		pick = $urandom_range(99);
		chan = 4'($urandom_range(15));
		if (pick < 35) begin
			if ($urandom_range(99) < 70)
				add_byte({mbep_pkg::MSG_NOTE_ON, chan});
			add_data_pair($urandom_range(99) < 25);
		end else if (pick < 55) begin
			if ($urandom_range(99) < 70)
				add_byte({mbep_pkg::MSG_NOTE_OFF, chan});
			add_data_pair($urandom_range(99) < 10);
		end else if (pick < 63) begin
			add_byte({mbep_pkg::MSG_PITCH_BEND, chan});
			add_data_pair(1'b0);
		end else if (pick < 75) begin
			case ($urandom_range(4))
			0: add_byte({MSG_POLY_TOUCH, chan});
			1: add_byte({MSG_CONTROL, chan});
			2: add_byte({MSG_PROGRAM, chan});
			3: add_byte({MSG_CHAN_TOUCH, chan});
			default: add_byte({MSG_SYSTEM, 1'b0, 3'($urandom_range(7))});
			endcase
			repeat ($urandom_range(2)) add_byte(8'($urandom_range(127)));
		end else if (pick < 85) begin
			add_byte({5'b11111, 3'($urandom_range(7))});
		end else begin
			add_byte(8'($urandom_range(255)));
		end
	endtask

	task automatic run_random(input int target);
		counted_bytes = 0;
		while (counted_bytes < target)
			add_message();
	endtask

	// The sender stays quiet until every predicted event has been popped.
	task automatic wait_drain();
		do begin
			@(posedge clk);
			#1;
		end while (tx_bytes.size() != 0 || push || predicted_events.size() != 0);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: data with no count armed, every real-time byte including
		// the ignored ones, note on and velocity-zero note off under running
		// status, note off on the top channel, pitch bend giving nothing,
		// real-time inside a message, and a non-note status that keeps the
		// count so the completion check decodes it to nothing.
		add_byte(8'h00);
		add_byte(mbep_pkg::RT_TICK);
		add_byte(mbep_pkg::RT_SEQ_START);
		add_byte(mbep_pkg::RT_CONTINUE);
		add_byte(mbep_pkg::RT_STOP);
		add_byte(RT_UNDEF_F9);
		add_byte(RT_UNDEF_FD);
		add_byte(RT_SENSE);
		add_byte(RT_SYS_RESET);
		add_byte({mbep_pkg::MSG_NOTE_ON, 4'h0});
		add_byte(8'h00);
		add_byte(8'h7F);
		add_byte(8'h7F);
		add_byte(8'h00);
		add_byte({mbep_pkg::MSG_NOTE_OFF, 4'hF});
		add_byte(8'h55);
		add_byte(8'h2A);
		add_byte({mbep_pkg::MSG_PITCH_BEND, 4'h3});
		add_byte(8'h00);
		add_byte(8'h7F);
		add_byte({mbep_pkg::MSG_NOTE_ON, 4'hA});
		add_byte(8'h40);
		add_byte(mbep_pkg::RT_TICK);
		add_byte(8'h01);
		add_byte({MSG_PROGRAM, 4'h5});
		add_byte(8'h11);
		add_byte(SYSEX_START);
		add_byte(8'h22);
		add_byte(SYSEX_END);
		wait_drain();

		run_random(100);
		wait_drain();

		send_idle_pct = 65;
		run_random(100);
		wait_drain();

		send_idle_pct = 0;
		recv_stall_pct = 65;
		run_random(100);
		wait_drain();

		send_idle_pct = 16;
		recv_stall_pct = 16;
		run_random(100);
		wait_drain();

		// Back pressure: the receiver stops popping while the sender pushes
		// without a break, so the job queue fills and full holds it off.
		send_idle_pct = 0;
		recv_stall_pct = 0;
		run_random(100);
		hold_go = 1'b1;
		wait_drain();

		repeat (TAIL_CYCLES) @(posedge clk);
		#1;
		if (error_count == 0 && predicted_events.size() == 0)
			$display("midi_byte_event_parser_unit_tb OK");
		else
			$display("midi_byte_event_parser_unit_tb NOT OK");
		$finish;
	end

endmodule
